// ===== rtl/chrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache replacement hit tracker package
// Geometry constants, shared types and the saturating increment used by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package chrt_pkg;

	// Address split and directory geometry.
	localparam int ADDR_BITS   = 32;
	localparam int ADDR_EXT    = 64;
	localparam int OFFSET_BITS = 5;
	localparam int INDEX_BITS  = 4;
	localparam int TAG_BITS    = 23;
	localparam int WAYS        = 4;
	localparam int NSETS       = 1 << INDEX_BITS;
	localparam int WAY_BITS    = $clog2(WAYS);

	// Event counters: one group of four per access kind.
	localparam int CNT_BITS     = 32;
	localparam int CNT_NUM      = 8;
	localparam int CNT_IDX_BITS = $clog2(CNT_NUM);
	localparam int CNT_SEL_BITS = 2;

	localparam logic [CNT_SEL_BITS-1:0] CNT_LRU_HIT   = 2'd0;
	localparam logic [CNT_SEL_BITS-1:0] CNT_LRU_MISS  = 2'd1;
	localparam logic [CNT_SEL_BITS-1:0] CNT_PLRU_HIT  = 2'd2;
	localparam logic [CNT_SEL_BITS-1:0] CNT_PLRU_MISS = 2'd3;

	// Result transfer layout.
	localparam int OUT_FIELD_BITS = 2 + 4 * CNT_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

	// One set's tags, and one set's recency order (most recent first).
	typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;
	typedef logic [WAYS-1:0][WAY_BITS-1:0] order_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} ctrl_sts_t;

	// Counter increment that sticks at the all-ones value.
	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
		logic [CNT_BITS-1:0] r;
		r = (c == {CNT_BITS{1'b1}}) ? c : CNT_BITS'(c + 1'b1);
		return r;
	endfunction

endpackage

// ===== rtl/chrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cache replacement hit tracker controller
// Two-state sequencer: takes an access, then commits the directory update
// and the result once the output register is free.
// ----------------------------------------------------------------------------
module chrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  chrt_pkg::ctrl_sts_t sts,
	output chrt_pkg::ctrl_cmd_t cmd
);
	import chrt_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt   = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// A captured access is always followed by a lookup cycle.
	a_capture_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_LOOKUP) && !s_tready)
		else $error("capture did not enter lookup");

	// A lookup waits as long as the result register is held.
	a_lookup_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) && sts.out_busy |=> (state_q == ST_LOOKUP))
		else $error("lookup left while output busy");

	// After a commit the block is ready for the next access.
	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> s_tready)
		else $error("not ready after commit");
`endif

endmodule

// ===== rtl/chrt_dp.sv =====
// ----------------------------------------------------------------------------
// Cache replacement hit tracker datapath
// Tag memories, valid bits, LRU order, PLRU recent bits, event counters and
// the result register.
// ----------------------------------------------------------------------------
module chrt_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [chrt_pkg::ADDR_BITS-1:0]        s_tdata,
	input  logic                                  s_tuser,
	input  chrt_pkg::ctrl_cmd_t                   cmd,
	output chrt_pkg::ctrl_sts_t                   sts,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [chrt_pkg::OUT_DATA_BITS-1:0]    m_tdata
);
	import chrt_pkg::*;

	// Tag memories, one row per set; undefined until written.
	tag_row_t lru_mem [NSETS];
	tag_row_t plru_mem [NSETS];

	// Directory state held in flip-flops.
	logic [NSETS-1:0][WAYS-1:0] lru_vld_q;
	logic [NSETS-1:0][WAYS-1:0] plru_vld_q;
	logic [NSETS-1:0][WAYS-1:0] plru_mru_q;
	order_t                     lru_ord_q [NSETS];
	logic [CNT_BITS-1:0]        cnt_q [CNT_NUM];

	// Access captured at the input transfer.
	logic [ADDR_EXT-1:0]   addr_ext;
	logic [INDEX_BITS-1:0] set_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic                  kind_s1;
	tag_row_t              lru_row_s1;
	tag_row_t              plru_row_s1;

	// LRU lookup and update.
	order_t                lru_ord;
	order_t                lru_ord_new;
	logic [WAYS-1:0]       lru_vld;
	logic                  lru_hit;
	logic [WAY_BITS-1:0]   lru_pos;
	logic [WAY_BITS-1:0]   lru_way;
	tag_row_t              lru_row_new;

	// PLRU lookup and update.
	logic [WAYS-1:0]       plru_mru;
	logic [WAYS-1:0]       plru_mru_set;
	logic [WAYS-1:0]       plru_mru_new;
	logic [WAYS-1:0]       plru_vld;
	logic                  plru_hit;
	logic                  plru_fill;
	logic                  free_found;
	logic [WAY_BITS-1:0]   free_way;
	logic [WAY_BITS-1:0]   plru_way;
	tag_row_t              plru_row_new;

	// Counter values after this access.
	logic [CNT_IDX_BITS-1:0] idx_lh;
	logic [CNT_IDX_BITS-1:0] idx_lm;
	logic [CNT_IDX_BITS-1:0] idx_ph;
	logic [CNT_IDX_BITS-1:0] idx_pm;
	logic [CNT_BITS-1:0]     lh_cnt;
	logic [CNT_BITS-1:0]     lm_cnt;
	logic [CNT_BITS-1:0]     ph_cnt;
	logic [CNT_BITS-1:0]     pm_cnt;

	// Result register.
	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;

	assign addr_ext = {{(ADDR_EXT - ADDR_BITS){1'b0}}, s_tdata};

	// Capture the access fields and read both tag rows of its set.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_s1      <= addr_ext[OFFSET_BITS +: INDEX_BITS];
			tag_s1      <= addr_ext[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
			kind_s1     <= s_tuser;
			lru_row_s1  <= lru_mem[addr_ext[OFFSET_BITS +: INDEX_BITS]];
			plru_row_s1 <= plru_mem[addr_ext[OFFSET_BITS +: INDEX_BITS]];
		end
	end

	// True LRU: search in recency order, then move the way to the front.
	always_comb begin
		lru_ord     = lru_ord_q[set_s1];
		lru_vld     = lru_vld_q[set_s1];
		lru_hit     = 1'b0;
		lru_pos     = WAY_BITS'(WAYS - 1);
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (lru_vld[lru_ord[p]] && (lru_row_s1[lru_ord[p]] == tag_s1)) begin
				lru_hit = 1'b1;
				lru_pos = WAY_BITS'(p);
			end
		end
		lru_way = lru_ord[lru_pos];
		for (int p = 0; p < WAYS; p++) begin
			if (p == 0) begin
				lru_ord_new[p] = lru_way;
			end else if (WAY_BITS'(p) <= lru_pos) begin
				lru_ord_new[p] = lru_ord[p-1];
			end else begin
				lru_ord_new[p] = lru_ord[p];
			end
		end
		lru_row_new = lru_row_s1;
		if (!lru_hit) begin
			lru_row_new[lru_way] = tag_s1;
		end
	end

	// Bit PLRU: hit sets the way's bit, a miss fills the first clear way,
	// and a full set of bits collapses to the way just used.
	always_comb begin
		plru_mru   = plru_mru_q[set_s1];
		plru_vld   = plru_vld_q[set_s1];
		plru_hit   = 1'b0;
		plru_way   = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (plru_vld[w] && (plru_row_s1[w] == tag_s1)) begin
				plru_hit = 1'b1;
				plru_way = WAY_BITS'(w);
			end
			if (!plru_mru[w]) begin
				free_found = 1'b1;
				free_way   = WAY_BITS'(w);
			end
		end
		plru_fill = !plru_hit && free_found;
		if (plru_fill) begin
			plru_way = free_way;
		end
		plru_mru_set = plru_mru;
		if (plru_hit || plru_fill) begin
			plru_mru_set[plru_way] = 1'b1;
		end
		if (&plru_mru_set) begin
			plru_mru_new           = '0;
			plru_mru_new[plru_way] = 1'b1;
		end else begin
			plru_mru_new = plru_mru_set;
		end
		plru_row_new = plru_row_s1;
		if (plru_fill) begin
			plru_row_new[plru_way] = tag_s1;
		end
	end

	// Saturating counters of this access kind.
	always_comb begin
		idx_lh = {kind_s1, CNT_LRU_HIT};
		idx_lm = {kind_s1, CNT_LRU_MISS};
		idx_ph = {kind_s1, CNT_PLRU_HIT};
		idx_pm = {kind_s1, CNT_PLRU_MISS};
		lh_cnt = lru_hit  ? sat_inc(cnt_q[idx_lh]) : cnt_q[idx_lh];
		lm_cnt = lru_hit  ? cnt_q[idx_lm] : sat_inc(cnt_q[idx_lm]);
		ph_cnt = plru_hit ? sat_inc(cnt_q[idx_ph]) : cnt_q[idx_ph];
		pm_cnt = plru_hit ? cnt_q[idx_pm] : sat_inc(cnt_q[idx_pm]);
	end

	// Tag memory writes.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			lru_mem[set_s1]  <= lru_row_new;
			plru_mem[set_s1] <= plru_row_new;
		end
	end

	// Directory state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lru_vld_q  <= '0;
			plru_vld_q <= '0;
			plru_mru_q <= '0;
			for (int s = 0; s < NSETS; s++) begin
				for (int p = 0; p < WAYS; p++) begin
					lru_ord_q[s][p] <= WAY_BITS'(p);
				end
			end
			for (int c = 0; c < CNT_NUM; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (cmd.commit) begin
			lru_vld_q[set_s1][lru_way] <= 1'b1;
			lru_ord_q[set_s1]          <= lru_ord_new;
			if (plru_fill) begin
				plru_vld_q[set_s1][plru_way] <= 1'b1;
			end
			plru_mru_q[set_s1] <= plru_mru_new;
			cnt_q[idx_lh]      <= lh_cnt;
			cnt_q[idx_lm]      <= lm_cnt;
			cnt_q[idx_ph]      <= ph_cnt;
			cnt_q[idx_pm]      <= pm_cnt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= {{OUT_PAD_BITS{1'b0}}, pm_cnt, ph_cnt, lm_cnt, lh_cnt,
				plru_hit, lru_hit};
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;
	assign sts.out_busy = m_tvalid_q && !m_tready;

`ifndef ASSERT_OFF
	// A commit never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid_q && !m_tready))
		else $error("result overwritten");

	// Every commit presents a result.
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit without result");

	// The set just touched keeps at least one recent bit.
	a_plru_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (plru_mru_q[$past(set_s1)] != '0))
		else $error("plru bits of set all clear");

	// The set just touched holds at least one valid LRU way.
	a_lru_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (lru_vld_q[$past(set_s1)] != '0))
		else $error("lru set without valid way");
`endif

endmodule

// ===== rtl/cache_replacement_hit_tracker.sv =====
// ----------------------------------------------------------------------------
// Cache replacement hit tracker
// Each access passes through two steps: the capture step takes the address
// and reads the set's tag rows from the tag memories, and the commit step
// compares, updates the true LRU and bit-PLRU directories and the counters,
// and loads the result register. A result waiting at the output holds the
// commit, but the next access is taken as soon as the previous one has
// committed. The address is split from the low end into offset, set index
// and tag. Per access kind the hit and miss counts of both policies saturate
// at all ones and are reported with this access included. Input tdata
// carries the address, tuser the instruction flag.
// ----------------------------------------------------------------------------
module cache_replacement_hit_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] address
	input  logic [chrt_pkg::ADDR_BITS-1:0]     s_tdata,
	// [0] is_instruction
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] lru_hit, [1] plru_hit, [33:2] lru_hit_count, [65:34] lru_miss_count,
	// [97:66] plru_hit_count, [129:98] plru_miss_count, [135:130] zero
	output logic [chrt_pkg::OUT_DATA_BITS-1:0] m_tdata
);
	import chrt_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Sequencer.
	chrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Directories, counters and result register.
	chrt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
